### rtl/tdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdr_pkg: shared types and constants
// Payload structs, command kinds, register indexes and datapath widths of the
// triangle depth rasterizer.
// ----------------------------------------------------------------------------
package tdr_pkg;

  localparam int MAX_WIDTH_DEF   = 256;
  localparam int MAX_HEIGHT_DEF  = 256;
  localparam int DEPTH_BITS_DEF  = 16;
  localparam int FACE_BITS_DEF   = 16;
  localparam int OBJECT_BITS_DEF = 8;

  localparam int XY_W        = 16;  // vertex x, y (Q2.14)
  localparam int Z_W         = 24;  // vertex depth (Q8.16)
  localparam int SIZE_W      = 9;   // size registers
  localparam int OBJ_W       = 8;   // object register
  localparam int CW          = 28;  // scaled coordinates
  localparam int EW          = 60;  // edge values and their sum
  localparam int DW          = 64;  // divider operands
  localparam int WT_BITS     = 16;  // barycentric weight fraction
  localparam int RECIP_BITS  = 40;  // reciprocal depth fraction
  localparam int RW          = 42;  // signed reciprocal
  localparam int STEP_W      = 6;   // divider step count
  localparam int Q_DEPTH     = 2;   // command queue entries

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] K_NOP   = 3'd0;
  localparam logic [2:0] K_CLEAR = 3'd1;
  localparam logic [2:0] K_DRAW  = 3'd2;
  localparam logic [2:0] K_CULL  = 3'd3;
  localparam logic [2:0] K_READ  = 3'd4;

  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CUR_OBJECT = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] vertex_a_x;
    logic signed [15:0] vertex_a_y;
    logic signed [15:0] vertex_b_x;
    logic signed [15:0] vertex_b_y;
    logic signed [15:0] vertex_c_x;
    logic signed [15:0] vertex_c_y;
    logic signed [23:0] vertex_a_depth;
    logic signed [23:0] vertex_b_depth;
    logic signed [23:0] vertex_c_depth;
    logic [15:0]        face_number;
    logic [15:0]        pixel_address;
  } tdr_in_t;

  typedef struct packed {
    logic [15:0] read_depth;
    logic [15:0] read_face;
    logic [7:0]  read_object;
    logic [16:0] pixels_updated;
    logic        triangle_culled;
  } tdr_out_t;

  typedef struct packed {
    logic [2:0] kind;
    tdr_in_t    item;
  } tdr_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tdr_q_stat_t;

  typedef struct packed {
    logic              start;
    logic [DW-1:0]     num;
    logic [DW-1:0]     den;
    logic [STEP_W-1:0] steps;
  } tdr_div_req_t;

endpackage
`default_nettype wire

### rtl/tdr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdr_front: command intake
// Registers an accepted transaction, sorts it by operation and culls back
// facing or zero area triangles, then pushes it into the command queue.
// ----------------------------------------------------------------------------
module tdr_front import tdr_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         accept,
  input  tdr_in_t     in_data,
  input  tdr_q_stat_t q_stat,
  output logic        push,
  output tdr_cmd_t    cmd,
  output logic        hold
);

  logic    fr_valid_r, fr_valid_nxt;
  tdr_in_t fr_item_r;

  logic signed [XY_W:0]     d_ac_y, d_ab_x, d_ab_y, d_ac_x;
  logic signed [2*XY_W+1:0] m1, m2;
  logic signed [2*XY_W+2:0] area;

  always_comb begin
    d_ac_y = {fr_item_r.vertex_a_y[XY_W-1], fr_item_r.vertex_a_y}
           - {fr_item_r.vertex_c_y[XY_W-1], fr_item_r.vertex_c_y};
    d_ab_x = {fr_item_r.vertex_a_x[XY_W-1], fr_item_r.vertex_a_x}
           - {fr_item_r.vertex_b_x[XY_W-1], fr_item_r.vertex_b_x};
    d_ab_y = {fr_item_r.vertex_a_y[XY_W-1], fr_item_r.vertex_a_y}
           - {fr_item_r.vertex_b_y[XY_W-1], fr_item_r.vertex_b_y};
    d_ac_x = {fr_item_r.vertex_a_x[XY_W-1], fr_item_r.vertex_a_x}
           - {fr_item_r.vertex_c_x[XY_W-1], fr_item_r.vertex_c_x};
    m1 = d_ac_y * d_ab_x;
    m2 = d_ab_y * d_ac_x;
    area = {m1[2*XY_W+1], m1} - {m2[2*XY_W+1], m2};
  end

  always_comb begin
    cmd.item = fr_item_r;
    case (fr_item_r.operation)
      OP_CLEAR: cmd.kind = K_CLEAR;
      OP_DRAW: begin
        // clockwise or degenerate: no pixel work at all
        if (area[2*XY_W+2] || (area == '0)) cmd.kind = K_CULL;
        else cmd.kind = K_DRAW;
      end
      OP_READ: cmd.kind = K_READ;
      default: cmd.kind = K_NOP;
    endcase
  end

  assign push = fr_valid_r & ~q_stat.full;
  assign hold = fr_valid_r & q_stat.full;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) fr_valid_nxt = 1'b1;
    else if (push) fr_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fr_valid_r <= 1'b0;
    else fr_valid_r <= fr_valid_nxt;
    if (accept) fr_item_r <= in_data;
  end

endmodule
`default_nettype wire

### rtl/tdr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdr_queue: command queue
// Short FIFO of classified commands between intake and execution.
// ----------------------------------------------------------------------------
module tdr_queue import tdr_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         push,
  input  tdr_cmd_t    push_cmd,
  input  wire         pop,
  output tdr_cmd_t    head,
  output tdr_q_stat_t q_stat
);

  localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  tdr_cmd_t         ent_r [Q_DEPTH];
  logic [QPW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPW:0]     cnt_r, cnt_nxt;

  assign head         = ent_r[rp_r];
  assign q_stat.full  = (cnt_r == (QPW+1)'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == QPW'(Q_DEPTH-1)) ? '0 : wp_r + 1'b1;
    if (pop) rp_nxt = (rp_r == QPW'(Q_DEPTH-1)) ? '0 : rp_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) ent_r[wp_r] <= push_cmd;
  end

endmodule
`default_nettype wire

### rtl/tdr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdr_div: serial fraction divider
// Computes floor(num * 2^steps / den) for num <= den, one quotient bit per
// cycle with a restoring step.
// ----------------------------------------------------------------------------
module tdr_div import tdr_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  input  tdr_div_req_t req,
  output logic         done,
  output logic [DW-1:0] quo
);

  logic [DW-1:0]     rem_r, rem_nxt, den_r, den_nxt, quo_r, quo_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt, done_r, done_nxt;

  logic [DW-1:0] n_clamp;
  logic          q0;
  logic [DW:0]   rem2;
  logic          ge;

  assign done = done_r;
  assign quo  = quo_r;

  always_comb begin
    n_clamp  = (req.num > req.den) ? req.den : req.num;
    q0       = (n_clamp >= req.den);
    rem2     = {rem_r, 1'b0};
    ge       = (rem2 >= {1'b0, den_r});
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      den_nxt = req.den;
      cnt_nxt = req.steps;
      if (req.den == '0) begin
        quo_nxt  = '0;
        done_nxt = 1'b1;
      end else begin
        quo_nxt = DW'(q0);
        rem_nxt = q0 ? (n_clamp - req.den) : n_clamp;
        if (req.steps == '0) done_nxt = 1'b1;
        else run_nxt = 1'b1;
      end
    end else if (run_r) begin
      rem_nxt = ge ? DW'(rem2 - {1'b0, den_r}) : DW'(rem2);
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule
`default_nettype wire

### rtl/tdr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdr_back: command execution
// Runs clear sweeps, pixel reads and the per pixel raster loop against the
// depth, face and object stores, and issues one result per command.
// ----------------------------------------------------------------------------
module tdr_back import tdr_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
  parameter int FACE_BITS   = FACE_BITS_DEF,
  parameter int OBJECT_BITS = OBJECT_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  tdr_cmd_t         head,
  input  tdr_q_stat_t      q_stat,
  output logic             pop,
  input  wire [SIZE_W-1:0] map_width,
  input  wire [SIZE_W-1:0] map_height,
  input  wire [OBJ_W-1:0]  current_object,
  output logic             out_valid,
  output tdr_out_t         out_data,
  output logic             init_busy
);

  localparam int PIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW  = (PIX > 1) ? $clog2(PIX) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam logic [DEPTH_BITS-1:0] FAR = '1;
  localparam logic [DW-1:0] ONE_R = DW'(1) << RECIP_BITS;

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_CLEAR = 5'd2;
  localparam logic [4:0] S_RECIP = 5'd3;
  localparam logic [4:0] S_SCALE = 5'd4;
  localparam logic [4:0] S_EDGE  = 5'd5;
  localparam logic [4:0] S_TEST  = 5'd6;
  localparam logic [4:0] S_L1    = 5'd7;
  localparam logic [4:0] S_L2    = 5'd8;
  localparam logic [4:0] S_SUM   = 5'd9;
  localparam logic [4:0] S_CHK   = 5'd10;
  localparam logic [4:0] S_DEPTH = 5'd11;
  localparam logic [4:0] S_RD    = 5'd12;
  localparam logic [4:0] S_CMP   = 5'd13;
  localparam logic [4:0] S_NEXT  = 5'd14;
  localparam logic [4:0] S_DONE  = 5'd15;
  localparam logic [4:0] S_READ  = 5'd16;
  localparam logic [4:0] S_READ2 = 5'd17;

  // stores
  logic [DEPTH_BITS-1:0]  dmem [PIX];
  logic [FACE_BITS-1:0]   fmem [PIX];
  logic [OBJECT_BITS-1:0] omem [PIX];
  logic [DEPTH_BITS-1:0]  rd_depth_r;
  logic [FACE_BITS-1:0]   rd_face_r;
  logic [OBJECT_BITS-1:0] rd_obj_r;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa, mem_ra;
  logic [DEPTH_BITS-1:0]  mem_wd;
  logic [FACE_BITS-1:0]   mem_wf;
  logic [OBJECT_BITS-1:0] mem_wo;

  // control and datapath registers
  logic [4:0]             state_r, state_nxt;
  logic [1:0]             k_r, k_nxt;
  logic                   ph_r, ph_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  tdr_cmd_t               cmd_r, cmd_nxt;
  logic [WW-1:0]          w_r, w_nxt, xi_r, xi_nxt;
  logic [HW-1:0]          h_r, h_nxt, yi_r, yi_nxt;
  logic [AW-1:0]          row_r, row_nxt;
  logic [OBJECT_BITS-1:0] obj_r, obj_nxt;
  logic signed [RW-1:0]   r_r [3];
  logic signed [RW-1:0]   r_nxt [3];
  logic signed [CW-1:0]   sx_r [3];
  logic signed [CW-1:0]   sx_nxt [3];
  logic signed [CW-1:0]   sy_r [3];
  logic signed [CW-1:0]   sy_nxt [3];
  logic signed [EW-1:0]   e_r [3];
  logic signed [EW-1:0]   e_nxt [3];
  logic [EW-1:0]          ds_r, ds_nxt;
  logic [WT_BITS:0]       l1_r, l1_nxt, l2_r, l2_nxt;
  logic signed [DW-1:0]   s_r, s_nxt;
  logic [DEPTH_BITS-1:0]  q_r, q_nxt;
  logic [16:0]            cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  tdr_out_t               out_data_r, out_data_nxt;

  tdr_div_req_t  div_req;
  logic          div_done;
  logic [DW-1:0] div_quo;

  tdr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  // selected operands
  logic signed [XY_W-1:0]  vx [3];
  logic signed [XY_W-1:0]  vy [3];
  logic signed [Z_W-1:0]   vz [3];
  logic signed [Z_W-1:0]   zsel;
  logic [Z_W-1:0]          zmag;
  logic [WW-1:0]           w_clamp;
  logic [HW-1:0]           h_clamp;
  logic signed [CW-1:0]    vxe, vye, we, he;
  logic signed [2*CW-1:0]  mx, my;
  logic signed [CW-1:0]    xpos, ypos, px, py, qx, qy;
  logic signed [CW:0]      d1, d2, d3, d4;
  logic signed [2*CW+1:0]  m1, m2;
  logic signed [EW-1:0]    edge_val;
  logic [EW-1:0]           ds_sum;
  logic signed [WT_BITS+1:0] l3, wsel;
  logic signed [RW-1:0]    rsel;
  logic signed [RW+WT_BITS+1:0] prod;
  logic signed [RW-1:0]    rq;
  logic [AW-1:0]           pix_idx;
  logic                    s_small;
  logic                    addr_ok;

  always_comb begin
    vx[0] = cmd_r.item.vertex_a_x;
    vx[1] = cmd_r.item.vertex_b_x;
    vx[2] = cmd_r.item.vertex_c_x;
    vy[0] = cmd_r.item.vertex_a_y;
    vy[1] = cmd_r.item.vertex_b_y;
    vy[2] = cmd_r.item.vertex_c_y;
    vz[0] = cmd_r.item.vertex_a_depth;
    vz[1] = cmd_r.item.vertex_b_depth;
    vz[2] = cmd_r.item.vertex_c_depth;

    w_clamp = (int'(map_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(map_width);
    h_clamp = (int'(map_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(map_height);

    zsel = vz[k_r];
    zmag = zsel[Z_W-1] ? (~zsel + 1'b1) : zsel;
    if (zmag == '0) zmag = Z_W'(1);
    rq = div_quo[RW-1:0];

    vxe = {{(CW-XY_W){vx[k_r][XY_W-1]}}, vx[k_r]};
    vye = {{(CW-XY_W){vy[k_r][XY_W-1]}}, vy[k_r]};
    we  = {{(CW-WW){1'b0}}, w_r};
    he  = {{(CW-HW){1'b0}}, h_r};
    mx  = vxe * we;
    my  = vye * he;

    // pixel center scaled by size*2^14: (2x+1-w) and (h-2y-1)
    xpos = ($signed({{(CW-WW-1){1'b0}}, xi_r, 1'b1}) - we) <<< 14;
    ypos = (he - $signed({{(CW-HW-1){1'b0}}, yi_r, 1'b1})) <<< 14;

    px = sx_r[k_r];
    py = sy_r[k_r];
    qx = (k_r == 2'd2) ? sx_r[0] : sx_r[k_r + 2'd1];
    qy = (k_r == 2'd2) ? sy_r[0] : sy_r[k_r + 2'd1];
    d1 = {ypos[CW-1], ypos} - {py[CW-1], py};
    d2 = {qx[CW-1], qx} - {px[CW-1], px};
    d3 = {xpos[CW-1], xpos} - {px[CW-1], px};
    d4 = {qy[CW-1], qy} - {py[CW-1], py};
    m1 = d1 * d2;
    m2 = d3 * d4;
    edge_val = {{(EW-2*CW-2){m1[2*CW+1]}}, m1} - {{(EW-2*CW-2){m2[2*CW+1]}}, m2};
    ds_sum = e_r[0] + e_r[1] + e_r[2];

    l3 = $signed((WT_BITS+2)'(1) << WT_BITS) - $signed({1'b0, l1_r})
       - $signed({1'b0, l2_r});
    case (k_r)
      2'd0:    wsel = $signed({1'b0, l1_r});
      2'd1:    wsel = $signed({1'b0, l2_r});
      default: wsel = l3;
    endcase
    rsel = r_r[k_r];
    prod = wsel * rsel;

    s_small = s_r[DW-1] || (s_r[DW-2:RECIP_BITS] == '0);
    pix_idx = row_r + AW'(xi_r);
    addr_ok = (int'(cmd_r.item.pixel_address) < PIX);
  end

  assign init_busy = (state_r == S_INIT);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    ph_nxt    = ph_r;
    clr_nxt   = clr_r;
    cmd_nxt   = cmd_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    xi_nxt    = xi_r;
    yi_nxt    = yi_r;
    row_nxt   = row_r;
    obj_nxt   = obj_r;
    r_nxt     = r_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    e_nxt     = e_r;
    ds_nxt    = ds_r;
    l1_nxt    = l1_r;
    l2_nxt    = l2_r;
    s_nxt     = s_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = pix_idx;
    mem_wd    = q_r;
    mem_wf    = FACE_BITS'(cmd_r.item.face_number);
    mem_wo    = obj_r;
    mem_ra    = pix_idx;
    div_req.start = 1'b0;
    div_req.num   = DW'(1);
    div_req.den   = DW'(zmag);
    div_req.steps = STEP_W'(RECIP_BITS);

    case (state_r)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = FAR;
        mem_wf = '0;
        mem_wo = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(PIX - 1)) begin
          clr_nxt   = '0;
          state_nxt = S_IDLE;
          if (state_r == S_CLEAR) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
          end
        end
      end
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          cmd_nxt = head;
          w_nxt   = w_clamp;
          h_nxt   = h_clamp;
          obj_nxt = OBJECT_BITS'(current_object);
          k_nxt   = 2'd0;
          ph_nxt  = 1'b0;
          cnt_nxt = '0;
          case (head.kind)
            K_CLEAR: state_nxt = S_CLEAR;
            K_DRAW:  state_nxt = S_RECIP;
            K_READ:  state_nxt = S_READ;
            K_CULL: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_data_nxt.triangle_culled = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
            end
          endcase
        end
      end
      S_RECIP: begin
        if (!ph_r) begin
          div_req.start = 1'b1;
          ph_nxt = 1'b1;
        end else if (div_done) begin
          ph_nxt = 1'b0;
          r_nxt[k_r] = zsel[Z_W-1] ? -rq : rq;
          if (k_r == 2'd2) begin
            k_nxt     = 2'd0;
            state_nxt = S_SCALE;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      S_SCALE: begin
        sx_nxt[k_r] = mx[CW-1:0];
        sy_nxt[k_r] = my[CW-1:0];
        if (k_r == 2'd2) begin
          k_nxt  = 2'd0;
          xi_nxt = '0;
          yi_nxt = '0;
          row_nxt = '0;
          if (w_r == '0 || h_r == '0) state_nxt = S_DONE;
          else state_nxt = S_EDGE;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_EDGE: begin
        e_nxt[k_r] = edge_val;
        if (k_r == 2'd2) begin
          k_nxt     = 2'd0;
          state_nxt = S_TEST;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_TEST: begin
        ds_nxt = ds_sum;
        // drop pixels outside any edge
        if (e_r[0][EW-1] || e_r[1][EW-1] || e_r[2][EW-1] || (ds_sum == '0)) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_L1;
        end
      end
      S_L1, S_L2: begin
        div_req.num   = (state_r == S_L1) ? DW'(e_r[1]) : DW'(e_r[2]);
        div_req.den   = DW'(ds_r);
        div_req.steps = STEP_W'(WT_BITS);
        if (!ph_r) begin
          div_req.start = 1'b1;
          ph_nxt = 1'b1;
        end else if (div_done) begin
          ph_nxt = 1'b0;
          if (state_r == S_L1) begin
            l1_nxt    = div_quo[WT_BITS:0];
            state_nxt = S_L2;
          end else begin
            l2_nxt    = div_quo[WT_BITS:0];
            k_nxt     = 2'd0;
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (k_r == 2'd0) s_nxt = DW'(prod);
        else s_nxt = s_r + DW'(prod);
        if (k_r == 2'd2) begin
          k_nxt     = 2'd0;
          state_nxt = S_CHK;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_CHK: begin
        // depth negative, infinite or beyond the far plane
        if (s_small) state_nxt = S_NEXT;
        else state_nxt = S_DEPTH;
      end
      S_DEPTH: begin
        div_req.num   = ONE_R;
        div_req.den   = s_r;
        div_req.steps = STEP_W'(DEPTH_BITS);
        if (!ph_r) begin
          div_req.start = 1'b1;
          ph_nxt = 1'b1;
        end else if (div_done) begin
          ph_nxt = 1'b0;
          q_nxt  = (div_quo > DW'(FAR)) ? FAR : div_quo[DEPTH_BITS-1:0];
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        if (q_r < rd_depth_r) begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        k_nxt     = 2'd0;
        state_nxt = S_EDGE;
        if (xi_r == w_r - 1'b1) begin
          xi_nxt  = '0;
          yi_nxt  = yi_r + 1'b1;
          row_nxt = row_r + AW'(MAX_WIDTH);
          if (yi_r == h_r - 1'b1) state_nxt = S_DONE;
        end else begin
          xi_nxt = xi_r + 1'b1;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        out_data_nxt.pixels_updated = cnt_r;
        state_nxt = S_IDLE;
      end
      S_READ: begin
        mem_ra    = AW'(cmd_r.item.pixel_address);
        state_nxt = S_READ2;
      end
      S_READ2: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        if (addr_ok) begin
          out_data_nxt.read_depth  = 16'(rd_depth_r);
          out_data_nxt.read_face   = 16'(rd_face_r);
          out_data_nxt.read_object = 8'(rd_obj_r);
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[mem_wa] <= mem_wd;
      fmem[mem_wa] <= mem_wf;
      omem[mem_wa] <= mem_wo;
    end
    rd_depth_r <= dmem[mem_ra];
    rd_face_r  <= fmem[mem_ra];
    rd_obj_r   <= omem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      k_r         <= '0;
      ph_r        <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      ph_r        <= ph_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    xi_r       <= xi_nxt;
    yi_r       <= yi_nxt;
    row_r      <= row_nxt;
    obj_r      <= obj_nxt;
    r_r        <= r_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    e_r        <= e_nxt;
    ds_r       <= ds_nxt;
    l1_r       <= l1_nxt;
    l2_r       <= l2_nxt;
    s_r        <= s_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

### rtl/triangle_depth_rasterizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_depth_rasterizer_top: triangle rasterizer with depth buffer
// Draws triangles into depth, face and object stores, clears and reads them.
//
// Usage:
//   Command channel: a transaction is taken when start is high and busy is
//   low. Operation 0 clears, 1 draws a triangle, 2 reads one pixel.
//   Result channel: every command gives exactly one result, shown for one
//   cycle with out_valid high; the receiver must take it then.
//   Register port: cfg_index/cfg_data written on cfg_valid (always ready);
//   the user must write only while no command is in flight; not enforced.
//   Operation: a read addresses the stores, then returns the registered
//   word. A clear sweeps all MAX_WIDTH*MAX_HEIGHT pixels, one per cycle.
//   A draw first takes the vertex depth reciprocals and scales the vertices,
//   then tests each pixel; pixels inside use the shared serial divider for
//   two weight divisions and, if the depth is in range, one depth division.
//   Queue and intake hold three commands behind the running one; busy rises then.
//   Reset: registers return to 64 x 64, object 0, and the stores are
//   cleared by a sweep over all MAX_WIDTH*MAX_HEIGHT pixels, busy held high.
// ----------------------------------------------------------------------------
module triangle_depth_rasterizer_top import tdr_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
  parameter int FACE_BITS   = FACE_BITS_DEF,
  parameter int OBJECT_BITS = OBJECT_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  tdr_in_t          in_data,
  output logic             out_valid,
  output tdr_out_t         out_data,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire [1:0]        cfg_index,
  input  wire [SIZE_W-1:0] cfg_data
);

  logic [SIZE_W-1:0] map_width_r, map_width_nxt;
  logic [SIZE_W-1:0] map_height_r, map_height_nxt;
  logic [OBJ_W-1:0]  cur_obj_r, cur_obj_nxt;

  logic        accept, push, pop, hold, init_busy;
  tdr_cmd_t    push_cmd, head;
  tdr_q_stat_t q_stat;
  logic [2:0]  pend_r, pend_nxt;

  assign cfg_ready = 1'b1;
  assign busy      = init_busy | hold;
  assign accept    = start & ~busy;

  always_comb begin
    map_width_nxt  = map_width_r;
    map_height_nxt = map_height_r;
    cur_obj_nxt    = cur_obj_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_width_nxt  = cfg_data;
        REG_MAP_HEIGHT: map_height_nxt = cfg_data;
        REG_CUR_OBJECT: cur_obj_nxt    = cfg_data[OBJ_W-1:0];
        default: ;
      endcase
    end
    pend_nxt = pend_r + {2'b0, accept} - {2'b0, out_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= SIZE_W'(64);
      map_height_r <= SIZE_W'(64);
      cur_obj_r    <= '0;
      pend_r       <= '0;
    end else begin
      map_width_r  <= map_width_nxt;
      map_height_r <= map_height_nxt;
      cur_obj_r    <= cur_obj_nxt;
      pend_r       <= pend_nxt;
    end
  end

  tdr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .in_data(in_data),
    .q_stat (q_stat),
    .push   (push),
    .cmd    (push_cmd),
    .hold   (hold)
  );

  tdr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  tdr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS),
    .FACE_BITS  (FACE_BITS),
    .OBJECT_BITS(OBJECT_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .map_width     (map_width_r),
    .map_height    (map_height_r),
    .current_object(cur_obj_r),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .init_busy     (init_busy)
  );

  // every result answers an earlier transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 3'd0))
    else $error("result without pending transaction");

  // intake stage, two queue entries and one command in execution at most
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("too many transactions in flight");

  // the store sweep after reset is silent and blocks intake
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> (!out_valid && busy && (pend_r == 3'd0)))
    else $error("activity during reset sweep");

endmodule
`default_nettype wire
